// ===== hw/rtl/wsframe_pkg.sv =====
// ----------------------------------------------------------------------------
// wsframe_pkg
// Shared types and codes for the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsframe_pkg;

    localparam int LEN_W = 63;

    typedef enum logic [2:0] {
        PH_HDR1    = 3'd0,
        PH_HDR2    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_KEY     = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    localparam logic [2:0] ACT_DATA    = 3'd0;
    localparam logic [2:0] ACT_CLOSE   = 3'd1;
    localparam logic [2:0] ACT_PING    = 3'd2;
    localparam logic [2:0] ACT_PONG    = 3'd3;
    localparam logic [2:0] ACT_UNKNOWN = 3'd4;

    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    typedef struct packed {
        logic             kind;
        logic             fin;
        logic [3:0]       opcode;
        logic [2:0]       action;
        logic             header_error;
        logic [LEN_W-1:0] frame_len;
        logic [7:0]       payload_byte;
        logic             last;
    } result_t;

    function automatic logic [2:0] action_of(input logic [3:0] op);
        logic [2:0] act;
        if (op <= OP_BINARY)
        begin
            act = ACT_DATA;
        end
        else if (op == OP_CLOSE)
        begin
            act = ACT_CLOSE;
        end
        else if (op == OP_PING)
        begin
            act = ACT_PING;
        end
        else if (op == OP_PONG)
        begin
            act = ACT_PONG;
        end
        else
        begin
            act = ACT_UNKNOWN;
        end
        return act;
    endfunction

endpackage

// ===== hw/rtl/wsframe_parser.sv =====
// ----------------------------------------------------------------------------
// wsframe_parser
// Frame parse state and the per-byte update: header decode, length and key
// capture, payload unmasking. Builds at most one result per byte.
// ----------------------------------------------------------------------------
module wsframe_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic [7:0]           in_byte,
    output logic                 has_result,
    output wsframe_pkg::result_t result
);
    import wsframe_pkg::*;

    phase_t           phase_reg,        phase_next;
    logic [7:0]       first_header_reg, first_header_next;
    logic [63:0]      length_accum_reg, length_accum_next;
    logic [2:0]       byte_counter_reg, byte_counter_next;
    logic [31:0]      mask_key_reg,     mask_key_next;
    logic [LEN_W-1:0] remaining_reg,    remaining_next;
    logic [1:0]       key_index_reg,    key_index_next;
    logic             error_seen_reg,   error_seen_next;

    logic [6:0]       len7;
    logic [63:0]      shifted_len;
    logic [7:0]       key_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HDR1;
            first_header_reg <= '0;
            length_accum_reg <= '0;
            byte_counter_reg <= '0;
            mask_key_reg     <= '0;
            remaining_reg    <= '0;
            key_index_reg    <= '0;
            error_seen_reg   <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg        <= phase_next;
            first_header_reg <= first_header_next;
            length_accum_reg <= length_accum_next;
            byte_counter_reg <= byte_counter_next;
            mask_key_reg     <= mask_key_next;
            remaining_reg    <= remaining_next;
            key_index_reg    <= key_index_next;
            error_seen_reg   <= error_seen_next;
        end
    end

    always_comb
    begin
        case (key_index_reg)
            2'd0:    key_byte = mask_key_reg[31:24];
            2'd1:    key_byte = mask_key_reg[23:16];
            2'd2:    key_byte = mask_key_reg[15:8];
            default: key_byte = mask_key_reg[7:0];
        endcase
    end

    assign len7        = in_byte[6:0];
    assign shifted_len = {length_accum_reg[55:0], in_byte};

    always_comb
    begin
        phase_next        = phase_reg;
        first_header_next = first_header_reg;
        length_accum_next = length_accum_reg;
        byte_counter_next = byte_counter_reg;
        mask_key_next     = mask_key_reg;
        remaining_next    = remaining_reg;
        key_index_next    = key_index_reg;
        error_seen_next   = error_seen_reg;
        has_result        = 1'b0;

        result.kind         = KIND_HEADER;
        result.fin          = first_header_reg[7];
        result.opcode       = first_header_reg[3:0];
        result.action       = action_of(first_header_reg[3:0]);
        result.header_error = error_seen_reg;
        result.frame_len    = length_accum_reg[LEN_W-1:0];
        result.payload_byte = 8'h00;
        result.last         = 1'b0;

        case (phase_reg)
            PH_HDR2:
            begin
                if (!in_byte[7])
                begin
                    error_seen_next = 1'b1;
                end
                if (len7 == LEN7_EXT16)
                begin
                    length_accum_next = '0;
                    byte_counter_next = 3'd1;
                    phase_next        = PH_EXTLEN;
                end
                else if (len7 == LEN7_EXT64)
                begin
                    length_accum_next = '0;
                    byte_counter_next = 3'd7;
                    phase_next        = PH_EXTLEN;
                end
                else
                begin
                    length_accum_next = {57'd0, len7};
                    byte_counter_next = 3'd3;
                    phase_next        = PH_KEY;
                end
            end
            PH_EXTLEN:
            begin
                length_accum_next = shifted_len;
                if (byte_counter_reg == 3'd0)
                begin
                    if (shifted_len[63])
                    begin
                        error_seen_next = 1'b1;
                    end
                    byte_counter_next = 3'd3;
                    phase_next        = PH_KEY;
                end
                else
                begin
                    byte_counter_next = byte_counter_reg - 3'd1;
                end
            end
            PH_KEY:
            begin
                mask_key_next = {mask_key_reg[23:0], in_byte};
                if (byte_counter_reg != 3'd0)
                begin
                    byte_counter_next = byte_counter_reg - 3'd1;
                end
                else
                begin
                    // Last key byte: emit the descriptor.
                    has_result     = 1'b1;
                    remaining_next = length_accum_reg[LEN_W-1:0];
                    key_index_next = 2'd0;
                    if (length_accum_reg[LEN_W-1:0] == '0)
                    begin
                        result.last = 1'b1;
                        phase_next  = PH_HDR1;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                has_result          = 1'b1;
                result.kind         = KIND_PAYLOAD;
                result.payload_byte = in_byte ^ key_byte;
                key_index_next      = key_index_reg + 2'd1;
                remaining_next      = remaining_reg - LEN_W'(1);
                if (remaining_reg == LEN_W'(1))
                begin
                    result.last = 1'b1;
                    phase_next  = PH_HDR1;
                end
            end
            default:
            begin
                first_header_next = in_byte;
                error_seen_next   = |in_byte[6:4];
                length_accum_next = '0;
                byte_counter_next = 3'd0;
                mask_key_next     = '0;
                remaining_next    = '0;
                key_index_next    = 2'd0;
                phase_next        = PH_HDR2;
            end
        endcase
    end

endmodule

// ===== hw/rtl/wsframe_out_reg.sv =====
// ----------------------------------------------------------------------------
// wsframe_out_reg
// Result register on the output channel; holds a result until it is taken.
// ----------------------------------------------------------------------------
module wsframe_out_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  wsframe_pkg::result_t load_data,
    input  logic                 take,
    output logic                 full,
    output wsframe_pkg::result_t data
);
    import wsframe_pkg::*;

    logic    full_reg, full_next;
    result_t data_reg;

    always_comb
    begin
        full_next = full_reg;
        if (load)
        begin
            full_next = 1'b1;
        end
        else if (take)
        begin
            full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign full = full_reg;
    assign data = data_reg;

endmodule

// ===== hw/rtl/websocket_frame_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unit
// RFC 6455 receive-side frame parser: header descriptor plus unmasked payload.
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle while the result side does not stall. Each
// byte passes an input register, the parse logic, and a result register,
// which presents the result. Header bytes yield nothing except the last
// masking-key byte, which yields the frame descriptor; each payload byte
// yields one unmasked byte. A stall on the result side holds the parser only
// when the byte in the input register would produce a result.
module websocket_frame_deframer_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         byte_valid,
    output logic                         byte_ready,
    input  logic [7:0]                   in_byte,
    output logic                         item_valid,
    input  logic                         item_ready,
    output logic                         kind,
    output logic                         fin,
    output logic [3:0]                   opcode,
    output logic [2:0]                   action,
    output logic                         header_error,
    output logic [wsframe_pkg::LEN_W-1:0] frame_len,
    output logic [7:0]                   payload_byte,
    output logic                         last
);
    import wsframe_pkg::*;

    logic       hold_valid_reg, hold_valid_next;
    logic [7:0] hold_byte_reg;
    logic       has_result;
    logic       advance;
    logic       out_full;
    logic       take;
    result_t    parse_result;
    result_t    out_data;

    assign take       = item_valid && item_ready;
    // Advance the held request unless it needs the result register and that
    // register stays occupied.
    assign advance    = hold_valid_reg && (!has_result || !out_full || item_ready);
    assign byte_ready = !hold_valid_reg || advance;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (byte_valid && byte_ready)
        begin
            hold_valid_next = 1'b1;
        end
        else if (advance)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
        begin
            hold_byte_reg <= in_byte;
        end
    end

    wsframe_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .in_byte    (hold_byte_reg),
        .has_result (has_result),
        .result     (parse_result)
    );

    wsframe_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && has_result),
        .load_data (parse_result),
        .take      (take),
        .full      (out_full),
        .data      (out_data)
    );

    assign item_valid   = out_full;
    assign kind         = out_data.kind;
    assign fin          = out_data.fin;
    assign opcode       = out_data.opcode;
    assign action       = out_data.action;
    assign header_error = out_data.header_error;
    assign frame_len    = out_data.frame_len;
    assign payload_byte = out_data.payload_byte;
    assign last         = out_data.last;

endmodule

// ===== test/websocket_frame_deframer_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer_checker
// Watches both channels of the deframer, tracks the frame parse state on
// every accepted stream byte, and compares each result item field by field
// against the oldest predicted item.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          byte_valid,
    input  logic                          byte_ready,
    input  logic [7:0]                    in_byte,
    input  logic                          item_valid,
    input  logic                          item_ready,
    input  logic                          kind,
    input  logic                          fin,
    input  logic [3:0]                    opcode,
    input  logic [2:0]                    action,
    input  logic                          header_error,
    input  logic [wsframe_pkg::LEN_W-1:0] frame_len,
    input  logic [7:0]                    payload_byte,
    input  logic                          last,
    output int                            fail_count,
    output int                            pending
);
    import wsframe_pkg::*;

    // parser state
    phase_t           parse_phase = PH_HDR1;
    logic [7:0]       hdr_byte    = '0;
    logic [63:0]      len_acc     = '0;
    logic [2:0]       hdr_left    = '0;
    logic [31:0]      key_word    = '0;
    logic [LEN_W-1:0] bytes_left  = '0;
    logic [1:0]       key_sel     = '0;
    logic             hdr_err     = 1'b0;

    result_t frame_items[$];
    result_t seen;
    int      errors = 0;

    assign seen = '{kind, fin, opcode, action, header_error, frame_len, payload_byte, last};

    function automatic logic [2:0] classify_opcode(input logic [3:0] op);
        logic [2:0] act;
        case (op)
            OP_CLOSE: act = ACT_CLOSE;
            OP_PING:  act = ACT_PING;
            OP_PONG:  act = ACT_PONG;
            default:  act = (op <= OP_BINARY) ? ACT_DATA : ACT_UNKNOWN;
        endcase
        return act;
    endfunction

    function automatic result_t frame_fields(input logic item_kind);
        result_t item;
        item              = '0;
        item.kind         = item_kind;
        item.fin          = hdr_byte[7];
        item.opcode       = hdr_byte[3:0];
        item.action       = classify_opcode(hdr_byte[3:0]);
        item.header_error = hdr_err;
        item.frame_len    = len_acc[LEN_W-1:0];
        return item;
    endfunction

    task automatic deframe_byte(input logic [7:0] b);
        result_t item;
        item = '0;
        case (parse_phase)
            PH_HDR2:
            begin
                if (!b[7])
                begin
                    hdr_err = 1'b1;
                end
                if (b[6:0] == LEN7_EXT16)
                begin
                    len_acc     = '0;
                    hdr_left    = 3'd1;
                    parse_phase = PH_EXTLEN;
                end
                else if (b[6:0] == LEN7_EXT64)
                begin
                    len_acc     = '0;
                    hdr_left    = 3'd7;
                    parse_phase = PH_EXTLEN;
                end
                else
                begin
                    len_acc     = {57'd0, b[6:0]};
                    hdr_left    = 3'd3;
                    parse_phase = PH_KEY;
                end
            end
            PH_EXTLEN:
            begin
                len_acc = {len_acc[55:0], b};
                if (hdr_left == 3'd0)
                begin
                    // a set top bit is an error, the low 63 bits still count
                    if (len_acc[63])
                    begin
                        hdr_err = 1'b1;
                    end
                    hdr_left    = 3'd3;
                    parse_phase = PH_KEY;
                end
                else
                begin
                    hdr_left = hdr_left - 3'd1;
                end
            end
            PH_KEY:
            begin
                key_word = {key_word[23:0], b};
                if (hdr_left != 3'd0)
                begin
                    hdr_left = hdr_left - 3'd1;
                end
                else
                begin
                    bytes_left  = len_acc[LEN_W-1:0];
                    key_sel     = 2'd0;
                    item        = frame_fields(KIND_HEADER);
                    item.last   = (bytes_left == '0);
                    parse_phase = (bytes_left == '0) ? PH_HDR1 : PH_PAYLOAD;
                    frame_items.push_back(item);
                end
            end
            PH_PAYLOAD:
            begin
                item              = frame_fields(KIND_PAYLOAD);
                // key bytes apply in wire order, first key byte at the top
                item.payload_byte = b ^ key_word[8 * (3 - int'(key_sel)) +: 8];
                key_sel           = key_sel + 2'd1;
                bytes_left        = bytes_left - LEN_W'(1);
                if (bytes_left == '0)
                begin
                    item.last   = 1'b1;
                    parse_phase = PH_HDR1;
                end
                frame_items.push_back(item);
            end
            default:
            begin
                hdr_byte    = b;
                hdr_err     = (b[6:4] != 3'b000);
                len_acc     = '0;
                hdr_left    = '0;
                key_word    = '0;
                bytes_left  = '0;
                key_sel     = '0;
                parse_phase = PH_HDR2;
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            parse_phase <= PH_HDR1;
            hdr_byte    <= '0;
            len_acc     <= '0;
            hdr_left    <= '0;
            key_word    <= '0;
            bytes_left  <= '0;
            key_sel     <= '0;
            hdr_err     <= 1'b0;
            frame_items.delete();
            pending     <= 0;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                if (frame_items.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result: expected none, actual %p", $time, seen);
                end
                else
                begin
                    want = frame_items.pop_front();
                    check_field("kind", 64'(want.kind), 64'(seen.kind));
                    check_field("fin", 64'(want.fin), 64'(seen.fin));
                    check_field("opcode", 64'(want.opcode), 64'(seen.opcode));
                    check_field("action", 64'(want.action), 64'(seen.action));
                    check_field("header_error", 64'(want.header_error),
                                64'(seen.header_error));
                    check_field("frame_len", 64'(want.frame_len), 64'(seen.frame_len));
                    check_field("payload_byte", 64'(want.payload_byte),
                                64'(seen.payload_byte));
                    check_field("last", 64'(want.last), 64'(seen.last));
                end
            end
            if (byte_valid && byte_ready)
            begin
                deframe_byte(in_byte);
            end
            pending <= frame_items.size();
        end
        fail_count <= errors;
    end

endmodule

// ===== test/tb_websocket_frame_deframer_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_websocket_frame_deframer_unit
// Drives WebSocket byte streams into the deframer: a few directed frames for
// zero length, header errors and an oversized 64-bit length, then random
// frames, mostly well formed, with random idle on both channels.
// ----------------------------------------------------------------------------
module tb_websocket_frame_deframer_unit;
    import wsframe_pkg::*;

    localparam logic [3:0] OP_CONT     = 4'h0;
    localparam logic [3:0] OP_TEXT     = 4'h1;
    localparam logic [3:0] OP_RESERVED = 4'hB;

    localparam int FORM_SHORT = 0;
    localparam int FORM_EXT16 = 1;
    localparam int FORM_EXT64 = 2;

    localparam int STREAM_BYTES = 1420;
    localparam int QUIET_TAIL   = 1250;
    localparam int STALL_LIMIT  = 2000;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             byte_valid   = 1'b0;
    logic             byte_ready;
    logic [7:0]       in_byte      = '0;
    logic             item_valid;
    logic             item_ready   = 1'b0;
    logic             kind;
    logic             fin;
    logic [3:0]       opcode;
    logic [2:0]       action;
    logic             header_error;
    logic [LEN_W-1:0] frame_len;
    logic [7:0]       payload_byte;
    logic             last;

    int fail_count;
    int pending;
    int bytes_sent = 0;
    int idle_odds  = 0;
    int stall_odds = 0;
    int stall_left = 0;
    int quiet_cycles = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    websocket_frame_deframer_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .in_byte      (in_byte),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .kind         (kind),
        .fin          (fin),
        .opcode       (opcode),
        .action       (action),
        .header_error (header_error),
        .frame_len    (frame_len),
        .payload_byte (payload_byte),
        .last         (last)
    );

    websocket_frame_deframer_checker frame_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .in_byte      (in_byte),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .kind         (kind),
        .fin          (fin),
        .opcode       (opcode),
        .action       (action),
        .header_error (header_error),
        .frame_len    (frame_len),
        .payload_byte (payload_byte),
        .last         (last),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // result side: random stall bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_ready <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
        end
        else if (stall_odds != 0 && $urandom_range(1, 100) <= stall_odds)
        begin
            item_ready <= 1'b0;
            stall_left <= $urandom_range(0, 8);
        end
        else
        begin
            item_ready <= 1'b1;
        end
    end

    // end the run when neither channel moves for too long
    always @(posedge clk)
    begin
        if ((byte_valid && byte_ready) || (item_valid && item_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // call at a rising edge; returns at the edge where the byte is accepted
    task automatic send_byte(input logic [7:0] b);
        if (idle_odds != 0 && $urandom_range(1, 100) <= idle_odds)
        begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        byte_valid <= 1'b1;
        in_byte    <= b;
        @(posedge clk);
        while (!byte_ready)
        begin
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] head, input logic masked, input int len_form,
                              input logic [63:0] wire_len, input int body_bytes);
        logic [6:0] len7;
        int         ext_bytes;
        case (len_form)
            FORM_EXT16:
            begin
                len7      = LEN7_EXT16;
                ext_bytes = 2;
            end
            FORM_EXT64:
            begin
                len7      = LEN7_EXT64;
                ext_bytes = 8;
            end
            default:
            begin
                len7      = wire_len[6:0];
                ext_bytes = 0;
            end
        endcase
        send_byte(head);
        send_byte({masked, len7});
        for (int i = ext_bytes - 1; i >= 0; i--)
        begin
            send_byte(wire_len[8 * i +: 8]);
        end
        repeat (4) send_byte(8'($urandom));
        repeat (body_bytes) send_byte(8'($urandom));
    endtask

    initial
    begin
        logic [7:0]  head;
        logic [3:0]  op;
        logic        masked;
        logic        well_formed;
        logic        top_bit;
        logic [63:0] wire_len;
        int          len_form;
        bit          paused;

        paused = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty close frame, then every header error with an unknown opcode,
        // then a 64-bit length with its top bit set
        send_frame({1'b1, 3'b000, OP_CLOSE}, 1'b1, FORM_SHORT, 64'd0, 0);
        send_frame({1'b0, 3'b111, 4'hF}, 1'b0, FORM_SHORT, 64'd1, 1);
        send_frame({1'b1, 3'b000, OP_PONG}, 1'b1, FORM_EXT64, 64'h8000_0000_0000_0001, 1);

        while (bytes_sent < STREAM_BYTES)
        begin
            if (bytes_sent > QUIET_TAIL)
            begin
                idle_odds = 0;
                stall_odds <= 0;
            end
            else
            begin
                idle_odds = 15 * $urandom_range(0, 2);
                stall_odds <= 15 * $urandom_range(0, 2);
            end

            // hold the stream until every predicted item has drained
            if (!paused && bytes_sent >= STREAM_BYTES / 2)
            begin
                paused = 1;
                byte_valid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                begin
                    @(posedge clk);
                end
            end

            well_formed = ($urandom_range(0, 99) < 85);
            if (well_formed)
            begin
                case ($urandom_range(0, 6))
                    0:       op = OP_CONT;
                    1:       op = OP_TEXT;
                    2:       op = OP_BINARY;
                    3:       op = OP_CLOSE;
                    4:       op = OP_PING;
                    5:       op = OP_PONG;
                    default: op = OP_RESERVED;
                endcase
                head   = {1'($urandom_range(0, 1)), 3'b000, op};
                masked = 1'b1;
            end
            else
            begin
                head   = 8'($urandom);
                masked = 1'($urandom_range(0, 1));
            end

            case ($urandom_range(0, 9))
                7, 8:
                begin
                    len_form = FORM_EXT16;
                    wire_len = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(126, 300))
                                                           : 64'($urandom_range(0, 30));
                end
                9:
                begin
                    len_form = FORM_EXT64;
                    top_bit  = well_formed ? 1'b0 : 1'($urandom_range(0, 1));
                    wire_len = {top_bit, 55'd0, 8'($urandom_range(0, 40))};
                end
                default:
                begin
                    len_form = FORM_SHORT;
                    if ($urandom_range(0, 9) == 0)
                    begin
                        wire_len = 64'd0;
                    end
                    else if ($urandom_range(0, 9) == 0)
                    begin
                        wire_len = 64'($urandom_range(21, 125));
                    end
                    else
                    begin
                        wire_len = 64'($urandom_range(1, 20));
                    end
                end
            endcase
            send_frame(head, masked, len_form, wire_len, int'(wire_len[15:0]));
        end

        // largest legal length: only the start of its payload is sent
        send_frame({1'b1, 3'b000, OP_BINARY}, 1'b1, FORM_EXT64, 64'h7FFF_FFFF_FFFF_FFFF, 24);
        byte_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        if (fail_count == 0 && pending == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
